[hdl/ordered_channel_reorder_buffer_macros.svh]
// Assertion macros used by the checker file.
`ifndef ORDERED_CHANNEL_REORDER_BUFFER_MACROS_SVH
`define ORDERED_CHANNEL_REORDER_BUFFER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define OCRB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define OCRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/ocrb_pkg.sv]
// ----------------------------------------------------------------------------
// ocrb_pkg
// Shared types and constants of the ordered channel reorder buffer.
// ----------------------------------------------------------------------------
package ocrb_pkg;
  localparam int unsigned PeerSlots = 4;
  localparam int unsigned Channels  = 32;
  localparam int unsigned Window    = 32;
  localparam int unsigned MaxOut    = 32;
  localparam int unsigned PeerW  = (PeerSlots > 1) ? $clog2(PeerSlots) : 1;
  localparam int unsigned ChanW  = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned SlotW  = $clog2(Window);
  localparam int unsigned QueueW = PeerW + ChanW;
  localparam int unsigned Queues = PeerSlots * Channels;
  localparam int unsigned HeldW  = QueueW + SlotW;
  localparam int unsigned Held   = Queues * Window;
  localparam int unsigned WinCap = ((Window - 1) < (MaxOut - 1)) ? (Window - 1) : (MaxOut - 1);
  localparam int unsigned IdxW   = 24;
  localparam int unsigned HandleW = 16;
  // Queue entry: next expected index and window head.
  localparam int unsigned QEntW  = IdxW + SlotW;

  typedef enum logic [1:0] {
    StDelivered = 2'd0,
    StHeld      = 2'd1,
    StDropOld   = 2'd2,
    StDropFar   = 2'd3
  } status_e;
endpackage

[hdl/ordered_channel_reorder_buffer.sv]
// ----------------------------------------------------------------------------
// ordered_channel_reorder_buffer
// Per-channel reorder buffer releasing ordered packets in index order.
// ----------------------------------------------------------------------------
// Channel | Signals                                   | Direction
// in      | in_valid_i/in_stall_o + five field ports  | descriptor in
// out     | out_valid_o/out_stall_i + six field ports | one report per transfer
// cfg     | cfg_we_i/cfg_wdata_i                      | reorder window
//
// After reset a clearing pass wipes the held store and the queue table; no
// input transfer is taken meanwhile. An unordered packet goes from idle
// straight to the output state; an ordered one first passes the read and
// evaluate states, and an in-order one and each released successor the walk
// read and walk evaluate states too: the following slot is read and cleared
// before a report is shown, so its last flag is known when it goes out.
// Output stalls simply hold the sequencer in its current result.
// ----------------------------------------------------------------------------
module ordered_channel_reorder_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  peer_slot_i,
  input  logic [4:0]  channel_i,
  input  logic [23:0] order_index_i,
  input  logic [15:0] payload_handle_i,
  input  logic        ordered_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  out_peer_o,
  output logic [4:0]  out_channel_o,
  output logic [23:0] out_index_o,
  output logic [15:0] out_handle_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i
);
  localparam int unsigned QueueW = ocrb_pkg::QueueW;
  localparam int unsigned SlotW  = ocrb_pkg::SlotW;
  localparam int unsigned HeldW  = ocrb_pkg::HeldW;
  localparam int unsigned IdxW   = ocrb_pkg::IdxW;
  localparam int unsigned HW     = ocrb_pkg::HandleW;
  localparam int unsigned QEntW  = ocrb_pkg::QEntW;
  localparam int unsigned EntW   = HW + 1;

  typedef enum logic [6:0] {
    SClear = 7'b0000001,
    SIdle  = 7'b0000010,
    SRead  = 7'b0000100,
    SEval  = 7'b0001000,
    SOut   = 7'b0010000,
    SWalkR = 7'b0100000,
    SWalkE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] win_q;

  // Latched descriptor.
  logic [1:0]  peer_q;
  logic [4:0]  chan_q;
  logic [23:0] idx_q;
  logic [15:0] hdl_q;
  logic [QueueW-1:0] queue_q;

  // Result register.
  logic        ov_q, ov_d, last_q;
  logic [1:0]  st_q;
  logic [23:0] oidx_q;
  logic [15:0] ohdl_q;

  // Walk state. The handle of the next successor waits here while the
  // current report is on the output.
  logic [IdxW-1:0]  ne_q;
  logic [SlotW-1:0] head_q;
  logic [5:0]       cnt_q;
  logic [HW-1:0]    nxt_hdl_q;
  logic [HeldW-1:0] clr_q;

  // Memory ports.
  logic              qwe;
  logic [QueueW-1:0] qwaddr;
  logic [QEntW-1:0]  qwdata, qrdata;
  logic              hwe;
  logic [HeldW-1:0]  hwaddr, hraddr;
  logic [EntW-1:0]   hwdata, hrdata;

  ocrb_ram #(.Width(QEntW), .Depth(ocrb_pkg::Queues)) u_queue_ram (
    .clk_i, .we_i(qwe), .waddr_i(qwaddr), .wdata_i(qwdata),
    .raddr_i(queue_q), .rdata_o(qrdata));

  ocrb_ram #(.Width(EntW), .Depth(ocrb_pkg::Held)) u_held_ram (
    .clk_i, .we_i(hwe), .waddr_i(hwaddr), .wdata_i(hwdata),
    .raddr_i(hraddr), .rdata_o(hrdata));

  // Queue selection with out-of-range peers and channels folded onto the last.
  logic [QueueW-1:0] in_queue;
  always_comb begin
    logic [ocrb_pkg::PeerW-1:0] p;
    logic [ocrb_pkg::ChanW-1:0] c;
    p = (32'(peer_slot_i) < ocrb_pkg::PeerSlots) ? ocrb_pkg::PeerW'(peer_slot_i)
                                                 : ocrb_pkg::PeerW'(ocrb_pkg::PeerSlots - 1);
    c = (32'(channel_i) < ocrb_pkg::Channels) ? ocrb_pkg::ChanW'(channel_i)
                                              : ocrb_pkg::ChanW'(ocrb_pkg::Channels - 1);
    in_queue = {p, c};
  end

  // Effective window after clamping.
  logic [5:0] eff_win;
  always_comb begin
    eff_win = win_q;
    if (win_q == 6'd0) eff_win = 6'd1;
    if (32'(win_q) > ocrb_pkg::WinCap) eff_win = 6'(ocrb_pkg::WinCap);
  end

  logic [IdxW-1:0]  ix_dist;
  logic [SlotW-1:0] rd_ne_head;
  logic [IdxW-1:0]  rd_ne;
  assign rd_ne      = qrdata[QEntW-1 -: IdxW];
  assign rd_ne_head = qrdata[SlotW-1:0];
  assign ix_dist    = idx_q - rd_ne;

  // A walk step continues while the next slot is occupied and the result
  // budget of the item is not used up.
  logic walk_more;
  assign walk_more = hrdata[HW] && (32'(cnt_q) < ocrb_pkg::MaxOut);

  logic out_take;
  assign out_take = ov_q && !out_stall_i;
  assign in_stall_o = (state_q != SIdle) || ov_q;

  always_comb begin
    state_d = state_q;
    ov_d = ov_q;
    qwe = 1'b0;
    qwaddr = queue_q;
    qwdata = {ne_q, head_q};
    hwe = 1'b0;
    hwaddr = {queue_q, head_q};
    hwdata = '0;
    hraddr = {queue_q, head_q};
    unique case (state_q)
      SClear: begin
        hwe = 1'b1;
        hwaddr = clr_q;
        qwe = 1'b1;
        qwaddr = clr_q[QueueW-1:0];
        qwdata = '0;
        if (clr_q == HeldW'(ocrb_pkg::Held - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i && !ov_q) begin
          state_d = ordered_i ? SRead : SOut;
          ov_d = !ordered_i;
        end
      end
      SRead: state_d = SEval;
      SEval: begin
        if (ix_dist == '0) begin
          // In-order arrival: look at the next slot before reporting.
          qwe = 1'b1;
          qwdata = {rd_ne + IdxW'(1), rd_ne_head + SlotW'(1)};
          state_d = SWalkR;
        end else begin
          if (!ix_dist[IdxW-1] && ix_dist <= IdxW'(eff_win)) begin
            hwe = 1'b1;
            hwaddr = {queue_q, rd_ne_head + ix_dist[SlotW-1:0]};
            hwdata = {1'b1, hdl_q};
          end
          ov_d = 1'b1;
          state_d = SOut;
        end
      end
      SOut: begin
        if (out_take) begin
          ov_d = 1'b0;
          state_d = last_q ? SIdle : SWalkR;
        end
      end
      SWalkR: state_d = SWalkE;
      SWalkE: begin
        if (walk_more) begin
          hwe = 1'b1;
          hwdata = '0;
          qwe = 1'b1;
          qwdata = {ne_q + IdxW'(1), head_q + SlotW'(1)};
        end
        ov_d = 1'b1;
        state_d = SOut;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      win_q   <= 6'd32;
      ov_q    <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      if (cfg_we_i) win_q <= cfg_wdata_i;
      if (state_q == SClear) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SIdle: begin
        peer_q  <= peer_slot_i;
        chan_q  <= channel_i;
        idx_q   <= order_index_i;
        hdl_q   <= payload_handle_i;
        queue_q <= in_queue;
        st_q    <= ocrb_pkg::StDelivered;
        oidx_q  <= order_index_i;
        ohdl_q  <= payload_handle_i;
        last_q  <= 1'b1;
        cnt_q   <= 6'd1;
      end
      SEval: begin
        ne_q   <= rd_ne + IdxW'(1);
        head_q <= rd_ne_head + SlotW'(1);
        last_q <= (ix_dist != '0);
        if (ix_dist == '0) st_q <= ocrb_pkg::StDelivered;
        else if (ix_dist[IdxW-1]) st_q <= ocrb_pkg::StDropOld;
        else if (ix_dist <= IdxW'(eff_win)) st_q <= ocrb_pkg::StHeld;
        else st_q <= ocrb_pkg::StDropFar;
      end
      SWalkE: begin
        // The report on show is the last one unless another successor follows.
        last_q <= !walk_more;
        if (walk_more) nxt_hdl_q <= hrdata[HW-1:0];
      end
      SOut: begin
        // Once the current report is taken, the waiting successor moves up.
        if (out_take && !last_q) begin
          oidx_q <= ne_q;
          ohdl_q <= nxt_hdl_q;
          ne_q   <= ne_q + IdxW'(1);
          head_q <= head_q + SlotW'(1);
          cnt_q  <= cnt_q + 6'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = ov_q;
  assign status_o      = st_q;
  assign out_peer_o    = peer_q;
  assign out_channel_o = chan_q;
  assign out_index_o   = oidx_q;
  assign out_handle_o  = ohdl_q;
  assign last_o        = last_q;
endmodule

[hdl/ocrb_ram.sv]
// ----------------------------------------------------------------------------
// ocrb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ocrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hdl/ocrb_checker.sv]
// ----------------------------------------------------------------------------
// ocrb_checker
// Port-level checks on the ordered channel reorder buffer.
// ----------------------------------------------------------------------------
`include "ordered_channel_reorder_buffer_macros.svh"
module ocrb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic        last_o
);
  `OCRB_ASSERT_IMP(a_held_last, clk_i, rst_ni, out_valid_o && status_o != ocrb_pkg::StDelivered, last_o)
  `OCRB_ASSERT_NEXT(a_in_blocks, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `OCRB_ASSERT_IMP(a_busy_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `OCRB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
endmodule

bind ordered_channel_reorder_buffer ocrb_checker u_ocrb_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .last_o);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the ordered channel reorder buffer. Packet
// descriptors are sent through the input channel while a behavioural model of
// the per-queue windows works out the reports that each descriptor causes;
// every report transfer is compared field by field with the oldest
// outstanding expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    ocrb_pkg::status_e status;
    logic [1:0]  peer;
    logic [4:0]  chan;
    logic [23:0] index;
    logic [15:0] handle;
    logic        last;
  } report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  peer_slot_i = '0;
  logic [4:0]  channel_i = '0;
  logic [23:0] order_index_i = '0;
  logic [15:0] payload_handle_i = '0;
  logic        ordered_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [1:0]  out_peer_o;
  logic [4:0]  out_channel_o;
  logic [23:0] out_index_o;
  logic [15:0] out_handle_o;
  logic        last_o;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;

  ordered_channel_reorder_buffer DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Model state: one queue per peer and channel.
  logic [23:0] next_idx [ocrb_pkg::Queues];
  logic [4:0]  win_head [ocrb_pkg::Queues];
  logic        slot_full [ocrb_pkg::Queues][ocrb_pkg::Window];
  logic [15:0] slot_handle [ocrb_pkg::Queues][ocrb_pkg::Window];
  logic [5:0]  window_reg;

  report_t     pending_reports[$];
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  int          errors = 0;
  int          reports_seen = 0;
  int          packets_sent = 0;
  int          idle_cycles = 0;

  // Works out the reports of one descriptor and advances the model.
  task automatic predict_reports(input logic [1:0] peer, input logic [4:0] chan,
                                 input logic [23:0] index, input logic [15:0] handle,
                                 input logic ord);
    int unsigned q;
    int unsigned win;
    int          count;
    logic [23:0] idx_dist;
    report_t     r;
    r = '{ocrb_pkg::StDelivered, peer, chan, index, handle, 1'b1};
    if (!ord) begin
      pending_reports.push_back(r);
      return;
    end
    q = peer * ocrb_pkg::Channels + chan;
    idx_dist = index - next_idx[q];
    win = (window_reg < 1) ? 1 : window_reg;
    if (win > ocrb_pkg::WinCap) win = ocrb_pkg::WinCap;
    if (idx_dist == 0) begin
      // In-order arrival: deliver it, then walk the held successors.
      count = 1;
      next_idx[q]++;
      win_head[q]++;
      r.last = 1'b0;
      pending_reports.push_back(r);
      while (count < ocrb_pkg::MaxOut && slot_full[q][win_head[q]]) begin
        r = '{ocrb_pkg::StDelivered, peer, chan, next_idx[q],
              slot_handle[q][win_head[q]], 1'b0};
        slot_full[q][win_head[q]] = 1'b0;
        next_idx[q]++;
        win_head[q]++;
        count++;
        pending_reports.push_back(r);
      end
      pending_reports[pending_reports.size() - 1].last = 1'b1;
    end else begin
      if (idx_dist[23]) begin
        r.status = ocrb_pkg::StDropOld;
      end else if (idx_dist <= win) begin
        r.status = ocrb_pkg::StHeld;
        slot_full[q][5'(win_head[q] + idx_dist)] = 1'b1;
        slot_handle[q][5'(win_head[q] + idx_dist)] = handle;
      end else begin
        r.status = ocrb_pkg::StDropFar;
      end
      pending_reports.push_back(r);
    end
  endtask

  // Sends one descriptor and waits for its transfer. Valid stays up after
  // the transfer so that descriptors can follow back to back; drain drops it.
  task automatic send_packet(input logic [1:0] peer, input logic [4:0] chan,
                             input logic [23:0] index, input logic [15:0] handle,
                             input logic ord);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    peer_slot_i <= peer;
    channel_i <= chan;
    order_index_i <= index;
    payload_handle_i <= handle;
    ordered_i <= ord;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_reports(peer, chan, index, handle, ord);
    packets_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    // Let the block settle idle before anything else changes.
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [5:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_reg = value;
  endtask

  // Current next index of a queue, for building well-formed sequences.
  function automatic logic [23:0] queue_next(input logic [1:0] peer, input logic [4:0] chan);
    return next_idx[peer * ocrb_pkg::Channels + chan];
  endfunction

  // Receiver stall: random, or held off entirely during the pressure test.
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Report checker. Sampling at the edge sees values settled before it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      report_t got;
      report_t want;
      got = '{ocrb_pkg::status_e'(status_o), out_peer_o, out_channel_o, out_index_o,
              out_handle_o, last_o};
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report %p", $time, got);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (got.status !== want.status || got.peer !== want.peer ||
            got.chan !== want.chan || got.index !== want.index ||
            got.handle !== want.handle || got.last !== want.last) begin
          $display("%0t: report mismatch, expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer; the clearing pass is allowed for.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Extremes of every field, unordered packets and out-of-window cases.
  task automatic test_directed;
    send_packet(2'd0, 5'd0, 24'h000000, 16'h0000, 1'b0);
    send_packet(2'd3, 5'd31, 24'hFFFFFF, 16'hFFFF, 1'b0);
    send_packet(2'd0, 5'd0, 24'd0, 16'h1111, 1'b1);
    send_packet(2'd0, 5'd0, 24'd3, 16'h3333, 1'b1);
    send_packet(2'd0, 5'd0, 24'd2, 16'h2222, 1'b1);
    send_packet(2'd0, 5'd0, 24'd3, 16'h3E3E, 1'b1);
    send_packet(2'd0, 5'd0, 24'd1, 16'hAAAA, 1'b1);
    send_packet(2'd0, 5'd0, 24'd0, 16'h5555, 1'b1);
    send_packet(2'd0, 5'd0, 24'hFFFFFF, 16'h0F0F, 1'b1);
    send_packet(2'd3, 5'd31, 24'd32, 16'hF0F0, 1'b1);
    send_packet(2'd3, 5'd31, 24'd33, 16'hBEEF, 1'b1);
    send_packet(2'd3, 5'd31, 24'h7FFFFF, 16'h1234, 1'b1);
    send_packet(2'd3, 5'd31, 24'h800000, 16'h4321, 1'b1);
  endtask

  // Fills a whole window then releases it with one arrival: longest walk.
  task automatic test_long_release;
    logic [23:0] base;
    base = queue_next(2'd2, 5'd7);
    for (int d = 31; d >= 1; d--) send_packet(2'd2, 5'd7, base + d, 16'($urandom), 1'b1);
    send_packet(2'd2, 5'd7, base, 16'($urandom), 1'b1);
  endtask

  // Window settings, the extremes among them; a shrink leaves held entries.
  task automatic test_window_settings;
    logic [23:0] base;
    base = queue_next(2'd1, 5'd4);
    send_packet(2'd1, 5'd4, base + 5, 16'hC0DE, 1'b1);
    write_window(6'd0);
    send_packet(2'd1, 5'd4, base + 1, 16'h0101, 1'b1);
    send_packet(2'd1, 5'd4, base + 2, 16'h0202, 1'b1);
    write_window(6'd63);
    send_packet(2'd1, 5'd4, base + 31, 16'h3131, 1'b1);
    send_packet(2'd1, 5'd4, base + 32, 16'h3232, 1'b1);
    write_window(6'd4);
    send_packet(2'd1, 5'd4, base + 4, 16'h0404, 1'b1);
    send_packet(2'd1, 5'd4, base, 16'h0000, 1'b1);
  endtask

  // Receiver holds off while descriptors keep coming, so the input stalls.
  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_packet(2'($urandom), 5'($urandom), 24'($urandom),
                                               16'($urandom), 1'b0);
    join
  endtask

  // Mostly well-formed bursts near each queue's next index, with some noise.
  task automatic test_random(input int count);
    logic [1:0]  peer;
    logic [4:0]  chan;
    logic [23:0] base;
    for (int i = 0; i < count; i++) begin
      peer = 2'($urandom_range(3));
      chan = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3));
      base = queue_next(peer, chan);
      case ($urandom_range(9))
        0: send_packet(peer, chan, 24'($urandom), 16'($urandom), 1'b1);
        1: send_packet(peer, chan, 24'($urandom), 16'($urandom), 1'b0);
        2: send_packet(peer, chan, base - 24'($urandom_range(1, 40)), 16'($urandom), 1'b1);
        3: send_packet(peer, chan, base + 24'($urandom_range(20, 60)), 16'($urandom), 1'b1);
        4, 5: send_packet(peer, chan, base, 16'($urandom), 1'b1);
        default: send_packet(peer, chan, base + 24'($urandom_range(1, 8)), 16'($urandom),
                             1'b1);
      endcase
    end
  endtask

  initial begin
    for (int q = 0; q < ocrb_pkg::Queues; q++) begin
      next_idx[q] = '0;
      win_head[q] = '0;
      for (int s = 0; s < ocrb_pkg::Window; s++) begin
        slot_full[q][s] = 1'b0;
        slot_handle[q][s] = '0;
      end
    end
    window_reg = 6'd32;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct = 14;
    recv_stall_pct = 87;
    test_directed();
    test_long_release();
    test_window_settings();
    write_window(6'd32);
    test_backpressure();
    test_random(45);
    send_gap_pct = 87;
    recv_stall_pct = 14;
    write_window(6'd8);
    test_random(45);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_window(6'd1);
    test_random(25);
    write_window(6'd31);
    test_random(25);
    drain();

    $display("tb: %0d descriptors sent, %0d reports checked", packets_sent, reports_seen);
    $display("tb: covered in-order release, holds, overwrites, drops and window changes");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
